// ----- sv/fvrgb_pkg.sv -----
// Shared constants, types and tables for the flow vector to RGB color block.
package fvrgb_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 12;
  localparam int CORDIC_STEPS    = 14;
  localparam int NORM_MSB        = 40;
  localparam int VEC_W           = 44;
  localparam int SHIFT_W         = 6;
  localparam int ANG_W           = 16;
  localparam int Z_W             = 16;
  localparam int BLEND_BITS      = 14;
  localparam int CHAN_W          = 22;
  localparam int SEG_W           = 3;

  localparam logic [ANG_W-1:0] EIGHTH_TURN   = 16'd8192;
  localparam logic [ANG_W-1:0] QUARTER_TURN  = 16'd16384;
  localparam logic [ANG_W-1:0] HALF_TURN     = 16'd32768;
  localparam logic [ANG_W-1:0] THREE_QUARTER = 16'd49152;

  localparam logic [SEG_W-1:0] SEG_LOW_HALF = 3'd4;
  localparam logic [SEG_W-1:0] SEG_LAST     = 3'd5;

  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_neg;
    logic swap;
    logic sm_zero;
    logic sm_eq;
    logic sat;
  } side_t;

  function automatic logic [13:0] atan_unit(input int i);
    logic [13:0] a;
    case (i)
      0:  a = 14'd8192;
      1:  a = 14'd4836;
      2:  a = 14'd2555;
      3:  a = 14'd1297;
      4:  a = 14'd651;
      5:  a = 14'd326;
      6:  a = 14'd163;
      7:  a = 14'd81;
      8:  a = 14'd41;
      9:  a = 14'd20;
      10: a = 14'd10;
      11: a = 14'd5;
      12: a = 14'd3;
      13: a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  function automatic logic [23:0] seg_start(input logic [SEG_W-1:0] s);
    logic [23:0] c;
    case (s)
      3'd0: c = {8'd0,   8'd0,   8'd255};
      3'd1: c = {8'd255, 8'd0,   8'd255};
      3'd2: c = {8'd255, 8'd64,  8'd64};
      3'd3: c = {8'd255, 8'd255, 8'd0};
      3'd4: c = {8'd0,   8'd255, 8'd0};
      3'd5: c = {8'd0,   8'd255, 8'd255};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] seg_end(input logic [SEG_W-1:0] s);
    logic [23:0] c;
    case (s)
      3'd0: c = {8'd255, 8'd0,   8'd255};
      3'd1: c = {8'd255, 8'd64,  8'd64};
      3'd2: c = {8'd255, 8'd255, 8'd0};
      3'd3: c = {8'd0,   8'd255, 8'd0};
      3'd4: c = {8'd0,   8'd255, 8'd255};
      3'd5: c = {8'd0,   8'd0,   8'd255};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/flow_vector_to_rgb_color.sv -----
// Top level of the flow vector to RGB color wheel pipeline.
// Takes one flow vector per clock and returns one RGB pixel per clock while
// out_tready allows. Every item passes 4 front stages, max(14, FRAC_BITS) iteration
// stages (a square root digit in the first FRAC_BITS, a CORDIC step in the first
// 14) and 5 color stages, and the sustained rate is one item per cycle. The whole
// pipeline advances together and holds while a finished pixel waits on out_tready.
module flow_vector_to_rgb_color #(
  parameter int COORD_WIDTH = fvrgb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // flow_x, flow_y, zero padding to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // red, green, blue
  output logic [23:0] out_tdata
);

  localparam int NSTEP = (FRAC_BITS > fvrgb_pkg::CORDIC_STEPS) ?
                         FRAC_BITS : fvrgb_pkg::CORDIC_STEPS;
  localparam int RW    = 2 * FRAC_BITS + 1;

  logic en;
  logic                               st_valid [NSTEP+1];
  fvrgb_pkg::side_t                   st_side  [NSTEP+1];
  logic [RW-1:0]                      st_rem   [NSTEP+1];
  logic [FRAC_BITS-1:0]               st_root  [NSTEP+1];
  logic signed [fvrgb_pkg::VEC_W-1:0] st_vx    [NSTEP+1];
  logic signed [fvrgb_pkg::VEC_W-1:0] st_vy    [NSTEP+1];
  logic signed [fvrgb_pkg::Z_W-1:0]   st_z     [NSTEP+1];
  logic [7:0] red, green, blue;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  fvrgb_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_x     (in_tdata[COORD_WIDTH-1:0]),
    .in_y     (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .out_valid(st_valid[0]),
    .out_side (st_side[0]),
    .out_rem  (st_rem[0]),
    .out_vx   (st_vx[0]),
    .out_vy   (st_vy[0])
  );

  assign st_root[0] = '0;
  assign st_z[0]    = '0;

  generate
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
      fvrgb_iter #(
        .FRAC_BITS(FRAC_BITS),
        .STEP     (s)
      ) u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (st_valid[s]),
        .in_side  (st_side[s]),
        .in_rem   (st_rem[s]),
        .in_root  (st_root[s]),
        .in_vx    (st_vx[s]),
        .in_vy    (st_vy[s]),
        .in_z     (st_z[s]),
        .out_valid(st_valid[s+1]),
        .out_side (st_side[s+1]),
        .out_rem  (st_rem[s+1]),
        .out_root (st_root[s+1]),
        .out_vx   (st_vx[s+1]),
        .out_vy   (st_vy[s+1]),
        .out_z    (st_z[s+1])
      );
    end
  endgenerate

  fvrgb_color #(
    .FRAC_BITS(FRAC_BITS)
  ) u_color (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (st_valid[NSTEP]),
    .in_side  (st_side[NSTEP]),
    .in_root  (st_root[NSTEP]),
    .in_z     (st_z[NSTEP]),
    .out_valid(out_tvalid),
    .out_red  (red),
    .out_green(green),
    .out_blue (blue)
  );

  assign out_tdata = {blue, green, red};

`ifndef ASSERT_OFF
  a_advance : assert property (@(posedge clk) in_tready == (!out_tvalid || out_tready))
    else $error("pipeline advance does not follow output handshake");
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (st_valid[NSTEP] == $past(st_valid[NSTEP])))
    else $error("iteration stage moved during stall");
`endif

endmodule

// ----- sv/fvrgb_front.sv -----
// Front stages: magnitudes, squares, octant compare, normalization.
module fvrgb_front #(
  parameter int COORD_WIDTH = fvrgb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = fvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [COORD_WIDTH-1:0]            in_x,
  input  logic [COORD_WIDTH-1:0]            in_y,
  output logic                              out_valid,
  output fvrgb_pkg::side_t                  out_side,
  output logic [2*FRAC_BITS:0]              out_rem,
  output logic signed [fvrgb_pkg::VEC_W-1:0] out_vx,
  output logic signed [fvrgb_pkg::VEC_W-1:0] out_vy
);

  localparam int CW  = COORD_WIDTH;
  localparam int R2W = 2 * COORD_WIDTH;
  localparam int RW  = 2 * FRAC_BITS + 1;
  localparam int MW  = (R2W > RW) ? R2W : RW;

  logic [CW-1:0] ax_nxt, ay_nxt, ax_r, ay_r;
  logic          v1_r, xz_r, xn_r, yn_r;

  logic [R2W-1:0] sqx_r, sqy_r;
  logic [CW-1:0]  lg_r, sm_r;
  logic           v2_r;
  fvrgb_pkg::side_t side2_r;

  logic [R2W-1:0] r2;
  logic [MW-1:0]  r2_wide;
  logic [fvrgb_pkg::SHIFT_W-1:0] msb;
  logic [CW-1:0]  lg3_r, sm3_r;
  logic [fvrgb_pkg::SHIFT_W-1:0] sh_r;
  logic [RW-1:0]  rem3_r;
  logic           v3_r;
  fvrgb_pkg::side_t side3_nxt;
  fvrgb_pkg::side_t side3_r;

  logic           v4_r;
  fvrgb_pkg::side_t side4_r;
  logic [RW-1:0]  rem4_r;
  logic signed [fvrgb_pkg::VEC_W-1:0] vx4_r, vy4_r;

  always_comb begin
    ax_nxt = in_x[CW-1] ? (CW'(0) - in_x) : in_x;
    ay_nxt = in_y[CW-1] ? (CW'(0) - in_y) : in_y;
  end

  assign r2      = sqx_r + sqy_r;
  assign r2_wide = MW'(r2);

  always_comb begin
    side3_nxt     = side2_r;
    side3_nxt.sat = ((r2 >> (2 * FRAC_BITS)) != '0);
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < CW; i++) begin
      if (lg_r[i]) begin
        msb = fvrgb_pkg::SHIFT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      xz_r <= (in_x == '0);
      xn_r <= in_x[CW-1];
      yn_r <= in_y[CW-1];

      sqx_r <= R2W'(ax_r) * R2W'(ax_r);
      sqy_r <= R2W'(ay_r) * R2W'(ay_r);
      lg_r  <= (ay_r > ax_r) ? ay_r : ax_r;
      sm_r  <= (ay_r > ax_r) ? ax_r : ay_r;
      side2_r.x_zero  <= xz_r;
      side2_r.x_neg   <= xn_r;
      side2_r.y_neg   <= yn_r;
      side2_r.swap    <= (ay_r > ax_r);
      side2_r.sm_zero <= (ax_r == '0) || (ay_r == '0);
      side2_r.sm_eq   <= (ax_r == ay_r);
      side2_r.sat     <= 1'b0;

      side3_r     <= side3_nxt;
      rem3_r      <= r2_wide[RW-1:0] & {1'b0, {(RW-1){1'b1}}};
      lg3_r       <= lg_r;
      sm3_r       <= sm_r;
      sh_r        <= fvrgb_pkg::SHIFT_W'(fvrgb_pkg::NORM_MSB) - msb;

      side4_r <= side3_r;
      rem4_r  <= rem3_r;
      vx4_r   <= $signed(fvrgb_pkg::VEC_W'(lg3_r) << sh_r);
      vy4_r   <= $signed(fvrgb_pkg::VEC_W'(sm3_r) << sh_r);
    end
  end

  assign out_valid = v4_r;
  assign out_side  = side4_r;
  assign out_rem   = rem4_r;
  assign out_vx    = vx4_r;
  assign out_vy    = vy4_r;

endmodule

// ----- sv/fvrgb_iter.sv -----
// Iteration stage: square root digit, CORDIC vectoring step, or both.
module fvrgb_iter #(
  parameter int FRAC_BITS = fvrgb_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  fvrgb_pkg::side_t                   in_side,
  input  logic [2*FRAC_BITS:0]               in_rem,
  input  logic [FRAC_BITS-1:0]               in_root,
  input  logic signed [fvrgb_pkg::VEC_W-1:0] in_vx,
  input  logic signed [fvrgb_pkg::VEC_W-1:0] in_vy,
  input  logic signed [fvrgb_pkg::Z_W-1:0]   in_z,
  output logic                               out_valid,
  output fvrgb_pkg::side_t                   out_side,
  output logic [2*FRAC_BITS:0]               out_rem,
  output logic [FRAC_BITS-1:0]               out_root,
  output logic signed [fvrgb_pkg::VEC_W-1:0] out_vx,
  output logic signed [fvrgb_pkg::VEC_W-1:0] out_vy,
  output logic signed [fvrgb_pkg::Z_W-1:0]   out_z
);

  localparam int RW = 2 * FRAC_BITS + 1;

  logic [RW-1:0]        rem_nxt, rem_r;
  logic [FRAC_BITS-1:0] root_nxt, root_r;
  logic signed [fvrgb_pkg::VEC_W-1:0] vx_nxt, vy_nxt, vx_r, vy_r;
  logic signed [fvrgb_pkg::Z_W-1:0]   z_nxt, z_r;
  logic                 valid_r;
  fvrgb_pkg::side_t     side_r;

  generate
    if (STEP < FRAC_BITS) begin : g_sqrt
      localparam int SI = FRAC_BITS - 1 - STEP;
      logic [RW-1:0] trial;
      always_comb begin
        trial = (RW'(in_root) << (SI + 1)) | (RW'(1) << (2 * SI));
        if (in_rem >= trial) begin
          rem_nxt  = in_rem - trial;
          root_nxt = in_root | (FRAC_BITS'(1) << SI);
        end else begin
          rem_nxt  = in_rem;
          root_nxt = in_root;
        end
      end
    end else begin : g_sqrt_hold
      assign rem_nxt  = in_rem;
      assign root_nxt = in_root;
    end

    if (STEP < fvrgb_pkg::CORDIC_STEPS) begin : g_cordic
      logic signed [fvrgb_pkg::Z_W-1:0] ang;
      always_comb begin
        ang = $signed(fvrgb_pkg::Z_W'(fvrgb_pkg::atan_unit(STEP)));
        if (!in_vy[fvrgb_pkg::VEC_W-1]) begin
          vx_nxt = in_vx + (in_vy >>> STEP);
          vy_nxt = in_vy - (in_vx >>> STEP);
          z_nxt  = in_z + ang;
        end else begin
          vx_nxt = in_vx - (in_vy >>> STEP);
          vy_nxt = in_vy + (in_vx >>> STEP);
          z_nxt  = in_z - ang;
        end
      end
    end else begin : g_cordic_hold
      assign vx_nxt = in_vx;
      assign vy_nxt = in_vy;
      assign z_nxt  = in_z;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      z_r    <= z_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_vx    = vx_r;
  assign out_vy    = vy_r;
  assign out_z     = z_r;

endmodule

// ----- sv/fvrgb_color.sv -----
// Back stages: angle mapping, segment blend, brightness scaling and clamp.
module fvrgb_color #(
  parameter int FRAC_BITS = fvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  fvrgb_pkg::side_t                 in_side,
  input  logic [FRAC_BITS-1:0]             in_root,
  input  logic signed [fvrgb_pkg::Z_W-1:0] in_z,
  output logic                             out_valid,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue
);

  localparam int LW = FRAC_BITS + 1;
  localparam int PW = LW + fvrgb_pkg::CHAN_W;
  localparam int SH = FRAC_BITS + fvrgb_pkg::BLEND_BITS;

  logic [fvrgb_pkg::ANG_W-1:0] oa, q, theta_nxt, theta_r;
  logic [LW-1:0] len1_r, len2_r, len3_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [fvrgb_pkg::SEG_W-1:0] seg_nxt, seg_r;
  logic [fvrgb_pkg::BLEND_BITS-1:0] b_nxt, b_r;

  logic [23:0] cs, ce;
  logic [fvrgb_pkg::BLEND_BITS:0] wb;
  logic [fvrgb_pkg::CHAN_W-1:0] c_nxt [3];
  logic [fvrgb_pkg::CHAN_W-1:0] c_r   [3];
  logic [PW-1:0] p_r [3];
  logic [PW-1:0] v   [3];
  logic [7:0]    o_r [3];

  always_comb begin
    if (in_side.sm_zero) begin
      oa = '0;
    end else if (in_side.sm_eq) begin
      oa = fvrgb_pkg::EIGHTH_TURN;
    end else if (in_z < 0) begin
      oa = '0;
    end else if (in_z > $signed(fvrgb_pkg::Z_W'(fvrgb_pkg::EIGHTH_TURN))) begin
      oa = fvrgb_pkg::EIGHTH_TURN;
    end else begin
      oa = in_z[fvrgb_pkg::ANG_W-1:0];
    end
    q = in_side.swap ? (fvrgb_pkg::QUARTER_TURN - oa) : oa;
    if (in_side.x_zero) begin
      theta_nxt = in_side.y_neg ? fvrgb_pkg::THREE_QUARTER : fvrgb_pkg::QUARTER_TURN;
    end else if (!in_side.x_neg) begin
      theta_nxt = in_side.y_neg ? (fvrgb_pkg::ANG_W'(0) - q) : q;
    end else begin
      theta_nxt = in_side.y_neg ? (fvrgb_pkg::HALF_TURN + q) : (fvrgb_pkg::HALF_TURN - q);
    end
  end

  always_comb begin
    if (theta_r < fvrgb_pkg::HALF_TURN) begin
      seg_nxt = theta_r[15:13];
      b_nxt   = {theta_r[12:0], 1'b0};
    end else if (theta_r < fvrgb_pkg::THREE_QUARTER) begin
      seg_nxt = fvrgb_pkg::SEG_LOW_HALF;
      b_nxt   = theta_r[fvrgb_pkg::BLEND_BITS-1:0];
    end else begin
      seg_nxt = fvrgb_pkg::SEG_LAST;
      b_nxt   = theta_r[fvrgb_pkg::BLEND_BITS-1:0];
    end
  end

  always_comb begin
    cs = fvrgb_pkg::seg_start(seg_r);
    ce = fvrgb_pkg::seg_end(seg_r);
    wb = (fvrgb_pkg::BLEND_BITS + 1)'(1 << fvrgb_pkg::BLEND_BITS) -
         (fvrgb_pkg::BLEND_BITS + 1)'(b_r);
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = fvrgb_pkg::CHAN_W'(cs[8*k +: 8]) * fvrgb_pkg::CHAN_W'(wb) +
                 fvrgb_pkg::CHAN_W'(ce[8*k +: 8]) * fvrgb_pkg::CHAN_W'(b_r);
    end
    for (int k = 0; k < 3; k++) begin
      v[k] = p_r[k] >> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= theta_nxt;
      len1_r  <= in_side.sat ? (LW'(1) << FRAC_BITS) : LW'(in_root);
      seg_r   <= seg_nxt;
      b_r     <= b_nxt;
      len2_r  <= len1_r;
      len3_r  <= len2_r;
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= c_nxt[k];
        p_r[k] <= PW'(len3_r) * PW'(c_r[k]);
        o_r[k] <= (v[k] > PW'(255)) ? 8'd255 : v[k][7:0];
      end
    end
  end

  assign out_valid = v5_r;
  assign out_red   = o_r[0];
  assign out_green = o_r[1];
  assign out_blue  = o_r[2];

endmodule

// ----- test/tb_flow_vector_to_rgb_color.sv -----
// Testbench for the flow vector to RGB color wheel block.
`timescale 1ns / 1ps

class rgb_scoreboard;
  logic [23:0] pending_q[$];
  int errors;
  int mismatches;

  static function logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  static function int unsigned atan_tab(int i);
    int unsigned t[14];
    t = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    return t[i];
  endfunction

  static function logic [63:0] octant_angle(logic [63:0] lg, logic [63:0] sm);
    int msb;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    longint z;
    if (sm == 0) return 0;
    if (sm >= lg) return 8192;
    msb = 0;
    while (msb < 63 && (lg >> (msb + 1)) != 0) msb++;
    vx = lg << (40 - msb);
    vy = sm << (40 - msb);
    z = 0;
    for (int i = 0; i < 14; i++) begin
      dx = vy >>> i;
      dy = $unsigned(vx) >> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        z = z + atan_tab(i);
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        z = z - atan_tab(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 8192) z = 8192;
    return z;
  endfunction

  static function logic [23:0] wheel_color(logic signed [15:0] fx, logic signed [15:0] fy);
    logic [7:0] cs[6][3];
    logic [7:0] ce[6][3];
    longint x;
    longint y;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] r2;
    logic [63:0] len;
    logic [63:0] q;
    logic [63:0] theta;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] v;
    int seg;
    logic [7:0] ch[3];
    cs = '{'{255, 0, 0}, '{255, 0, 255}, '{64, 64, 255}, '{0, 255, 255}, '{0, 255, 0},
           '{255, 255, 0}};
    ce = '{'{255, 0, 255}, '{64, 64, 255}, '{0, 255, 255}, '{0, 255, 0}, '{255, 255, 0},
           '{255, 0, 0}};
    x = fx;
    y = fy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    r2 = ax * ax + ay * ay;
    len = (r2 >= (64'd1 << 24)) ? 64'd4096 : isqrt(r2);
    if (x == 0) begin
      theta = (y >= 0) ? 16384 : 49152;
    end else begin
      if (ay <= ax) q = octant_angle(ax, ay);
      else q = 16384 - octant_angle(ay, ax);
      if (x > 0) theta = (y >= 0) ? q : 65536 - q;
      else theta = (y >= 0) ? 32768 - q : 32768 + q;
    end
    theta = theta & 64'hFFFF;
    if (theta < 32768) begin
      seg = theta >> 13;
      b = (theta & 8191) << 1;
    end else if (theta < 49152) begin
      seg = 4;
      b = theta - 32768;
    end else begin
      seg = 5;
      b = theta - 49152;
    end
    for (int k = 0; k < 3; k++) begin
      c = cs[seg][k] * (16384 - b) + ce[seg][k] * b;
      v = (len * c) >> 26;
      ch[k] = (v > 255) ? 8'd255 : v[7:0];
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  function void note_vector(logic [31:0] d);
    pending_q.push_back(wheel_color(d[15:0], d[31:16]));
  endfunction

  function void check_pixel(logic [23:0] got);
    logic [23:0] exp_c;
    if (pending_q.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected pixel %h", got);
      return;
    end
    exp_c = pending_q.pop_front();
    if (exp_c !== got) begin
      errors++;
      if (mismatches++ < 10)
        $display("pixel mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                 exp_c[7:0], exp_c[15:8], exp_c[23:16], got[7:0], got[15:8], got[23:16]);
    end
  endfunction
endclass

module tb_flow_vector_to_rgb_color;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  rgb_scoreboard sb;
  int idle_cycles = 0;
  bit stall_mode = 1'b0;

  always #4 clk = ~clk;

  flow_vector_to_rgb_color i_dut (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_vector(in_tdata);
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic send_vector(logic [15:0] fx, logic [15:0] fy);
    in_tvalid <= 1'b1;
    in_tdata <= {fy, fx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8191) - 4096);
      2: return 16'($urandom_range(0, 200) - 100);
      3: return 16'($urandom_range(0, 16) - 8);
      default: return 16'($urandom_range(0, 12000) - 6000);
    endcase
  endfunction

  initial begin
    logic [15:0] dx[$];
    logic [15:0] dy[$];
    logic [15:0] fx;
    int burst;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dx = '{0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4096, 16'hF000, 0, 0, 2896,
           16'hF4B0, 2896, 1, 16'hFFFF, 4095, 100, 16'hFF9C, 1000, 4096};
    dy = '{0, 4096, 16'hF000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0, 0, 1, 16'hFFFF, 2896,
           2896, 16'hF4B0, 1, 0, 0, 100, 16'hFF9C, 16'hFFFF, 16'hFFFF};
    foreach (dx[i]) send_vector(dx[i], dy[i]);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 1600; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        fx = rand_coord();
        send_vector(fx, $urandom_range(0, 9) == 0 ? 16'd0 : rand_coord());
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      if (n > 800 && n < 841) begin
        in_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ----- flow_vector_to_rgb_color.f -----
sv/fvrgb_pkg.sv
sv/fvrgb_front.sv
sv/fvrgb_iter.sv
sv/fvrgb_color.sv
sv/flow_vector_to_rgb_color.sv
test/tb_flow_vector_to_rgb_color.sv
